// File: sv/rfpw_pkg.sv
package rfpw_pkg;

	localparam int PANEL_WIDTH_DEF  = 84;
	localparam int PANEL_HEIGHT_DEF = 48;
	localparam int PAGE_ROWS        = 8;

	localparam logic REG_ROTATION = 1'b0;

	typedef enum logic [1:0] {
		MODE_DRAW  = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_FILL  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		logic load_item;
		logic pixel_write;
		logic sweep_write;
		logic sweep_item;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic new_is_sweep;
		logic sweep_last;
	} sts_t;

endpackage

// File: sv/rotated_framebuffer_pixel_writer_unit.sv
// channel | signals                                   | word
// cfg     | psel penable pwrite paddr pwdata prdata    | rotation at 0x0
// in      | in_valid in_ready                          | mode x y color byte_index
// out     | out_valid out_ready                        | read_byte pixel_written
//
// Draw and read words: store read at accept (IDLE), modify/write in ACCESS; result loaded there or in DONE.
// Clear and fill sweep the whole store in SWEEP, one store byte written a cycle, then load the result in DONE.
// After reset a zeroing sweep of all STORE_BYTES store bytes (504 by default) runs; in_ready low.
// A result waits in the output register; work stalls only when that register is still full.
module rotated_framebuffer_pixel_writer_unit
	import rfpw_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic        color,
	input  logic [8:0]  byte_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic        pixel_written
);

	logic [1:0] rotation_q;
	cmd_t       cmd;
	sts_t       sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ROTATION)) begin
			rotation_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ROTATION) ? {30'd0, rotation_q} : 32'd0;

	rfpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rfpw_datapath #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.rotation      (rotation_q),
		.mode          (mode),
		.x             (x),
		.y             (y),
		.color         (color),
		.byte_index    (byte_index),
		.read_byte     (read_byte),
		.pixel_written (pixel_written)
	);

endmodule

// File: sv/rfpw_datapath.sv
module rfpw_datapath
	import rfpw_pkg::*;
#(
	parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [1:0] rotation,
	input  logic [1:0] mode,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic       color,
	input  logic [8:0] byte_index,
	output logic [7:0] read_byte,
	output logic       pixel_written
);

	localparam int STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam logic [7:0] W_LOG  = 8'(PANEL_WIDTH);
	localparam logic [7:0] H_LOG  = 8'(PANEL_HEIGHT);
	localparam logic [7:0] W_M1   = 8'(PANEL_WIDTH - 1);
	localparam logic [7:0] H_M1   = 8'(PANEL_HEIGHT - 1);
	localparam logic [13:0] STORE_LIM = 14'(STORE_BYTES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

	logic [7:0] frame_mem [STORE_BYTES];

	mode_t             in_mode;
	logic [7:0]        lw, lh, px, py;
	logic              in_bounds;
	logic [13:0]       pix_idx, rd_idx;
	logic [ADDR_W-1:0] raddr;

	mode_t             mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [2:0]        bit_q;
	logic              color_q;
	logic              wr_ok_q;
	logic              rd_ok_q;
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [7:0]        read_byte_q;
	logic              pixel_written_q;

	logic [7:0]        bit_mask, mod_byte, fill_byte, res_byte;
	logic              res_written;

	assign in_mode = mode_t'(mode);

	always_comb begin
		lw = rotation[0] ? H_LOG : W_LOG;
		lh = rotation[0] ? W_LOG : H_LOG;
		in_bounds = (x < lw) && (y < lh);
		case (rotation)
			2'd1: begin
				px = y;
				py = H_M1 - x;
			end
			2'd2: begin
				px = W_M1 - x;
				py = H_M1 - y;
			end
			2'd3: begin
				px = W_M1 - y;
				py = x;
			end
			default: begin
				px = x;
				py = y;
			end
		endcase
		pix_idx = 14'(px) + 14'(py[7:3]) * 14'(PANEL_WIDTH);
		rd_idx  = 14'(byte_index);
		raddr   = (in_mode == MODE_READ) ? rd_idx[ADDR_W-1:0] : pix_idx[ADDR_W-1:0];
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q  <= in_mode;
			addr_q  <= pix_idx[ADDR_W-1:0];
			bit_q   <= py[2:0];
			color_q <= color;
			wr_ok_q <= in_bounds && (pix_idx < STORE_LIM);
			rd_ok_q <= rd_idx < STORE_LIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.sweep_write) begin
			cnt_q <= sts.sweep_last ? '0 : cnt_q + 1'b1;
		end
	end

	assign sts.sweep_last   = (cnt_q == LAST_ADDR);
	assign sts.new_is_sweep = (in_mode == MODE_CLEAR) || (in_mode == MODE_FILL);

	always_comb begin
		bit_mask  = 8'd1 << bit_q;
		mod_byte  = color_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
		fill_byte = (cmd.sweep_item && (mode_q == MODE_FILL)) ? 8'hFF : 8'h00;
		res_byte  = ((mode_q == MODE_READ) && rd_ok_q) ? rdata_q : 8'h00;
		res_written = (mode_q == MODE_DRAW) && wr_ok_q;
	end

	// frame store
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			rdata_q <= frame_mem[raddr];
		end
		if (cmd.sweep_write) begin
			frame_mem[cnt_q] <= fill_byte;
		end else if (cmd.pixel_write && res_written) begin
			frame_mem[addr_q] <= mod_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_byte_q     <= res_byte;
			pixel_written_q <= res_written;
		end
	end

	assign read_byte     = read_byte_q;
	assign pixel_written = pixel_written_q;

	a_cnt_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep_write && sts.sweep_last) |=> (cnt_q == '0))
		else $error("sweep counter did not wrap");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pixel_write && res_written) |-> (addr_q <= LAST_ADDR))
		else $error("pixel write outside store");

endmodule

// File: sv/rfpw_ctrl.sv
module rfpw_ctrl
	import rfpw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [4:0] {
		ST_INIT   = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_SWEEP  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_write = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = sts.new_is_sweep ? ST_SWEEP : ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.pixel_write = 1'b1;
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_write = 1'b1;
				cmd.sweep_item  = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second word taken while busy");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep_write && cmd.pixel_write))
		else $error("sweep and pixel write clash");

	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_ACCESS || $past(state_q) == ST_DONE))
		else $error("result without an item");

endmodule

// File: sim/testbench.sv
module testbench;
	import rfpw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = PANEL_WIDTH_DEF;
	localparam int H = PANEL_HEIGHT_DEF;
	localparam int STORE_BYTES = W * ((H + PAGE_ROWS - 1) / PAGE_ROWS);
	localparam logic [2:0] ROTATION_ADDR = {REG_ROTATION, 2'b00};
	localparam int WORDS_PER_PHASE = 200;

	class pixel_writer_scoreboard;
		logic [7:0] frame_bytes [STORE_BYTES];
		logic [1:0] rotation;
		logic [7:0] expected_byte [$];
		logic expected_written [$];
		int errors;

		function new();
			foreach (frame_bytes[i])
				frame_bytes[i] = 8'h00;
			rotation = 2'd0;
			errors = 0;
		endfunction

		function int outstanding();
			return expected_byte.size();
		endfunction

		// apply one accepted word to the shadow store and queue its result
		function void note_word(logic [1:0] m, logic [7:0] lx, logic [7:0] ly,
				logic c, logic [8:0] idx);
			int lw, lh, px, py, addr;
			logic [7:0] rd;
			logic wr;
			rd = 8'h00;
			wr = 1'b0;
			lw = rotation[0] ? H : W;
			lh = rotation[0] ? W : H;
			case (mode_t'(m))
				MODE_DRAW: begin
					if (lx < lw && ly < lh) begin
						case (rotation)
							2'd1: begin px = ly; py = H - 1 - lx; end
							2'd2: begin px = W - 1 - lx; py = H - 1 - ly; end
							2'd3: begin px = W - 1 - ly; py = lx; end
							default: begin px = lx; py = ly; end
						endcase
						addr = px + (py / PAGE_ROWS) * W;
						frame_bytes[addr][py % PAGE_ROWS] = c;
						wr = 1'b1;
					end
				end
				MODE_CLEAR: begin
					foreach (frame_bytes[i])
						frame_bytes[i] = 8'h00;
				end
				MODE_FILL: begin
					foreach (frame_bytes[i])
						frame_bytes[i] = 8'hFF;
				end
				default: begin
					if (idx < STORE_BYTES)
						rd = frame_bytes[idx];
				end
			endcase
			expected_byte.push_back(rd);
			expected_written.push_back(wr);
		endfunction

		function void check_result(logic [7:0] rd, logic wr);
			logic [7:0] exp_rd;
			logic exp_wr;
			if (expected_byte.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: read_byte %02h pixel_written %b", rd, wr);
				return;
			end
			exp_rd = expected_byte.pop_front();
			exp_wr = expected_written.pop_front();
			if (rd !== exp_rd || wr !== exp_wr) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: read_byte exp %02h got %02h, pixel_written exp %b got %b",
						exp_rd, rd, exp_wr, wr);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_DRAW;
	logic [7:0] x = '0;
	logic [7:0] y = '0;
	logic color = 1'b0;
	logic [8:0] byte_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_byte;
	logic pixel_written;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_left = 0;

	pixel_writer_scoreboard sb;

	rotated_framebuffer_pixel_writer_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= rx_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(read_byte, pixel_written);
			if (in_valid && in_ready)
				sb.note_word(mode, x, y, color, byte_index);
		end
	end

	task automatic write_rotation(logic [1:0] rot);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ROTATION_ADDR;
		pwdata <= {30'd0, rot};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.rotation = rot;
	endtask

	task automatic send_word(mode_t m, logic [7:0] lx, logic [7:0] ly, logic c,
			logic [8:0] idx);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		x <= lx;
		y <= ly;
		color <= c;
		byte_index <= idx;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering and let every outstanding word drain
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_random(logic [1:0] rot);
		int lw, lh, pick;
		lw = rot[0] ? H : W;
		lh = rot[0] ? W : H;
		pick = $urandom_range(99);
		if (pick < 55)
			send_word(MODE_DRAW, 8'($urandom_range(lw - 1)), 8'($urandom_range(lh - 1)),
				1'($urandom), 9'($urandom));
		else if (pick < 61)
			send_word(MODE_DRAW, 8'($urandom), 8'($urandom), 1'($urandom), 9'($urandom));
		else if (pick < 65)
			send_word(MODE_DRAW, 8'($urandom_range(1) ? lw - 1 + $urandom_range(1) : 0),
				8'($urandom_range(1) ? lh - 1 + $urandom_range(1) : 0), 1'($urandom),
				9'($urandom));
		else if (pick < 67)
			send_word(MODE_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 9'($urandom));
		else if (pick < 69)
			send_word(MODE_FILL, 8'($urandom), 8'($urandom), 1'($urandom), 9'($urandom));
		else if (pick < 95)
			send_word(MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom),
				9'($urandom_range(STORE_BYTES - 1)));
		else
			send_word(MODE_READ, 8'($urandom), 8'($urandom), 1'($urandom), 9'($urandom));
	endtask

	initial begin
		logic [1:0] rot_plan [8];
		int ph, n;
		rot_plan = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd0};
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_rotation(2'd0);
		send_word(MODE_DRAW, 0, 0, 1'b1, 0);
		send_word(MODE_DRAW, 8'(W - 1), 8'(H - 1), 1'b1, 0);
		send_word(MODE_DRAW, 8'(W), 0, 1'b1, 0);
		send_word(MODE_DRAW, 0, 8'(H), 1'b1, 0);
		send_word(MODE_DRAW, 8'hFF, 8'hFF, 1'b1, 9'h1FF);
		send_word(MODE_READ, 0, 0, 1'b0, 0);
		send_word(MODE_READ, 0, 0, 1'b0, 9'(W - 1));
		send_word(MODE_READ, 0, 0, 1'b0, 9'(STORE_BYTES - 1));
		send_word(MODE_READ, 0, 0, 1'b0, 9'(STORE_BYTES));
		send_word(MODE_READ, 8'hFF, 8'hFF, 1'b1, 9'h1FF);
		send_word(MODE_CLEAR, 0, 0, 1'b0, 0);
		send_word(MODE_READ, 0, 0, 1'b0, 0);
		send_word(MODE_FILL, 0, 0, 1'b0, 0);
		send_word(MODE_READ, 0, 0, 1'b0, 0);
		send_word(MODE_DRAW, 0, 0, 1'b0, 0);
		send_word(MODE_READ, 0, 0, 1'b0, 0);
		send_word(MODE_DRAW, 8'(W - 1), 8'(H - 1), 1'b0, 0);
		send_word(MODE_READ, 0, 0, 1'b0, 9'(STORE_BYTES - 1));
		send_word(MODE_READ, 0, 0, 1'b0, 9'h1FF);
		send_word(MODE_CLEAR, 8'hFF, 8'hFF, 1'b1, 9'h1FF);
		send_word(MODE_READ, 0, 0, 1'b0, 9'(STORE_BYTES - 1));

		for (ph = 0; ph < 8; ph++) begin
			wait_drained();
			write_rotation(rot_plan[ph]);
			case (ph % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 57; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 57; end
				default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
			endcase
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				// long receiver hold-off so the block backs up into its input
				if (ph == 4 && n == 20)
					hold_left = 400;
				send_random(rot_plan[ph]);
			end
		end

		wait_drained();
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
